// File: hw/rtl/gsdm_pkg.sv
// Package for the gear selector debounce monitor.
// Holds the item, state and configuration types, the codes and the lever decoder.
// Depends on nothing; gsdm_core and the top level import it.
package gsdm_pkg;

    localparam logic [2:0] GEAR_NEUTRAL = 3'd0;
    localparam logic [2:0] GEAR_PARK    = 3'd1;
    localparam logic [2:0] GEAR_DRIVE2  = 3'd2;
    localparam logic [2:0] GEAR_DRIVE1  = 3'd3;
    localparam logic [2:0] GEAR_REVERSE = 3'd4;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_NACK = 2'd1;

    localparam logic [1:0] REASON_NONE    = 2'd0;
    localparam logic [1:0] REASON_NACK    = 2'd1;
    localparam logic [1:0] REASON_NO_DATA = 2'd2;
    localparam logic [1:0] REASON_BACKOFF = 2'd3;

    localparam logic [1:0] REG_FAIL_LIMIT       = 2'd0;
    localparam logic [1:0] REG_SETTLE_COUNT     = 2'd1;
    localparam logic [1:0] REG_POLL_INTERVAL    = 2'd2;
    localparam logic [1:0] REG_BACKOFF_INTERVAL = 2'd3;

    localparam logic [7:0]  BAD_BYTE  = 8'hFF;
    localparam logic [3:0]  GEAR_BITS = 4'hF;
    localparam logic [15:0] CNT_MAX   = 16'hFFFF;

    typedef struct packed {
        logic       probe_ack;
        logic       reinit_ok;
        logic [1:0] read_status;
        logic [7:0] port_value;
    } t_in_item;

    typedef struct packed {
        logic [2:0]  gear;
        logic        connected;
        logic        in_backoff;
        logic        bus_recovery_request;
        logic [1:0]  reject_reason;
        logic [15:0] next_wait_ms;
        logic [15:0] valid_read_count;
        logic [15:0] invalid_read_count;
        logic [15:0] recovery_count;
        logic [7:0]  last_good_pattern;
    } t_out_item;

    typedef struct packed {
        logic [1:0]  index;
        logic [15:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic [3:0]  fail_limit;
        logic [2:0]  settle_count;
        logic [15:0] poll_interval_ms;
        logic [15:0] backoff_interval_ms;
    } t_cfg;

    typedef struct packed {
        logic [2:0]  committed_gear;
        logic [2:0]  candidate_gear;
        logic [2:0]  candidate_count;
        logic [3:0]  fail_streak;
        logic        link_up;
        logic [1:0]  last_reason;
        logic [15:0] good_reads;
        logic [15:0] bad_reads;
        logic [15:0] recoveries;
        logic [7:0]  good_pattern;
    } t_state;

    function automatic logic [2:0] decode_lever(input logic [7:0] port);
        logic [3:0] act;
        act = (~port[3:0]) & GEAR_BITS;
        case (act)
            4'b0001: decode_lever = GEAR_PARK;
            4'b0010: decode_lever = GEAR_DRIVE2;
            4'b0100: decode_lever = GEAR_DRIVE1;
            4'b1000: decode_lever = GEAR_REVERSE;
            default: decode_lever = GEAR_NEUTRAL;
        endcase
    endfunction

    function automatic logic [15:0] sat_inc(input logic [15:0] value);
        sat_inc = (value == CNT_MAX) ? value : value + 16'd1;
    endfunction

endpackage

// File: hw/rtl/gsdm_chan_if.sv
// Valid/ready channel interface used for the input, result and configuration ports.
// The payload type is a parameter; the block passes structs from gsdm_pkg.
interface gsdm_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hw/rtl/gsdm_core.sv
// Next-state and result logic for one poll outcome of the gear monitor.
// Purely combinational; uses the types, codes and functions of gsdm_pkg.
module gsdm_core
    import gsdm_pkg::*;
(
    input  t_state    i_state,
    input  t_cfg      i_cfg,
    input  t_in_item  i_item,
    output t_state    o_state,
    output t_out_item o_result
);

    logic        good;
    logic [2:0]  sample;
    logic [1:0]  fail_reason;
    logic        pulse;
    logic        back_after;
    logic [15:0] wait_ms;
    t_state      rec;
    t_state      n;

    assign good   = (i_item.read_status == STATUS_OK) && (i_item.port_value != BAD_BYTE);
    assign sample = decode_lever(i_item.port_value);

    always_comb begin
        if (i_item.read_status == STATUS_OK) begin
            fail_reason = REASON_NONE;
        end else if (i_item.read_status == STATUS_NACK) begin
            fail_reason = REASON_NACK;
        end else begin
            fail_reason = REASON_NO_DATA;
        end
    end

    // State after recording the read outcome alone.
    always_comb begin
        rec = i_state;
        if (good) begin
            rec.good_reads   = sat_inc(i_state.good_reads);
            rec.good_pattern = i_item.port_value;
            rec.last_reason  = REASON_NONE;
        end else begin
            rec.bad_reads   = sat_inc(i_state.bad_reads);
            rec.last_reason = fail_reason;
        end
    end

    always_comb begin
        n     = i_state;
        pulse = 1'b0;
        if (i_state.fail_streak >= i_cfg.fail_limit) begin
            if (!i_item.probe_ack) begin
                n.committed_gear  = GEAR_NEUTRAL;
                n.candidate_gear  = GEAR_NEUTRAL;
                n.candidate_count = 3'd0;
                n.last_reason     = REASON_BACKOFF;
            end else if (!i_item.reinit_ok) begin
                n.committed_gear  = GEAR_NEUTRAL;
                n.candidate_gear  = GEAR_NEUTRAL;
                n.candidate_count = 3'd0;
            end else begin
                n                 = rec;
                n.fail_streak     = 4'd0;
                n.link_up         = 1'b1;
                n.committed_gear  = GEAR_NEUTRAL;
                n.candidate_gear  = good ? sample : GEAR_NEUTRAL;
                n.candidate_count = 3'd1;
            end
        end else if (!good) begin
            n             = rec;
            n.fail_streak = i_state.fail_streak + 4'd1;
            if (n.fail_streak == i_cfg.fail_limit) begin
                n.link_up    = 1'b0;
                pulse        = 1'b1;
                n.recoveries = sat_inc(i_state.recoveries);
            end
            n.committed_gear  = GEAR_NEUTRAL;
            n.candidate_gear  = GEAR_NEUTRAL;
            n.candidate_count = 3'd0;
        end else begin
            n = rec;
            if (i_state.fail_streak != 4'd0) begin
                n.fail_streak = 4'd0;
                n.link_up     = 1'b1;
            end
            if (sample == i_state.candidate_gear) begin
                if (i_state.candidate_count < i_cfg.settle_count) begin
                    n.candidate_count = i_state.candidate_count + 3'd1;
                end
            end else begin
                n.candidate_gear  = sample;
                n.candidate_count = 3'd1;
            end
            if (n.candidate_count >= i_cfg.settle_count) begin
                n.committed_gear = n.candidate_gear;
            end
        end
    end

    assign back_after = n.fail_streak >= i_cfg.fail_limit;

    always_comb begin
        wait_ms = back_after ? i_cfg.backoff_interval_ms : i_cfg.poll_interval_ms;
        if (wait_ms == 16'd0) begin
            wait_ms = 16'd1;
        end
    end

    assign o_state = n;

    always_comb begin
        o_result.gear                 = n.committed_gear;
        o_result.connected            = n.link_up;
        o_result.in_backoff           = back_after;
        o_result.bus_recovery_request = pulse;
        o_result.reject_reason        = n.last_reason;
        o_result.next_wait_ms         = wait_ms;
        o_result.valid_read_count     = n.good_reads;
        o_result.invalid_read_count   = n.bad_reads;
        o_result.recovery_count       = n.recoveries;
        o_result.last_good_pattern    = n.good_pattern;
    end

endmodule

// File: hw/rtl/gear_selector_debounce_monitor.sv
// Gear selector debounce monitor: top level with input, state, configuration and result registers.
// Depends on gsdm_pkg, gsdm_chan_if and gsdm_core.
//
// Each input item is one poll outcome of the lever port expander; each produces
// exactly one result item. An accepted item sits in the input register, passes
// through the decode, debounce and link-state logic in gsdm_core, and is loaded
// into the result register once that register is empty or being read. One item
// is taken every cycle while the result side keeps up. While the result side
// stalls, the input register still takes one more item before input ready drops.
// Configuration writes are always accepted and take effect at once; they are
// meant to be issued only while no item is in flight.
module gear_selector_debounce_monitor
    import gsdm_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    gsdm_chan_if.sink   i_in,
    gsdm_chan_if.source o_out,
    gsdm_chan_if.sink   i_cfg
);

    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    t_state    r_state;
    t_state    n_state;
    t_out_item n_out_item;
    t_cfg      r_cfg;
    logic      move;

    assign move       = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || move;
    assign i_cfg.ready = 1'b1;

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_item;

    gsdm_core u_core (
        .i_state  (r_state),
        .i_cfg    (r_cfg),
        .i_item   (r_in_item),
        .o_state  (n_state),
        .o_result (n_out_item)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
        if (i_in.valid && i_in.ready) begin
            r_in_item <= i_in.data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (move) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
        if (move) begin
            r_out_item <= n_out_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.committed_gear  <= GEAR_NEUTRAL;
            r_state.candidate_gear  <= GEAR_NEUTRAL;
            r_state.candidate_count <= 3'd0;
            r_state.fail_streak     <= 4'd0;
            r_state.link_up         <= 1'b1;
            r_state.last_reason     <= REASON_NONE;
            r_state.good_reads      <= 16'd0;
            r_state.bad_reads       <= 16'd0;
            r_state.recoveries      <= 16'd0;
            r_state.good_pattern    <= BAD_BYTE;
        end else if (move) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.fail_limit          <= 4'd5;
            r_cfg.settle_count        <= 3'd2;
            r_cfg.poll_interval_ms    <= 16'd50;
            r_cfg.backoff_interval_ms <= 16'd1000;
        end else if (i_cfg.valid && i_cfg.ready) begin
            case (i_cfg.data.index)
                REG_FAIL_LIMIT:       r_cfg.fail_limit          <= i_cfg.data.data[3:0];
                REG_SETTLE_COUNT:     r_cfg.settle_count        <= i_cfg.data.data[2:0];
                REG_POLL_INTERVAL:    r_cfg.poll_interval_ms    <= i_cfg.data.data;
                REG_BACKOFF_INTERVAL: r_cfg.backoff_interval_ms <= i_cfg.data.data;
                default: ;
            endcase
        end
    end

    // A recovery request is only raised on the item that drops the link into backoff.
    a_pulse_means_backoff: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (move && n_out_item.bus_recovery_request) |->
            (n_out_item.in_backoff && !n_out_item.connected))
        else $error("recovery request without entering backoff");

    // A committed gear other than neutral implies the link is up.
    a_gear_needs_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state.committed_gear != GEAR_NEUTRAL) |-> r_state.link_up)
        else $error("gear committed while link is down");

    // The recovery counter moves only together with a recovery request.
    a_recovery_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!move || !n_out_item.bus_recovery_request) |=> $stable(r_state.recoveries))
        else $error("recovery counter changed without a request");

endmodule
